>>> hdl/hctok_pkg.sv
// ----------------------------------------------------------------------------
// hctok_pkg
// shared types and constants of the hex command line tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package hctok_pkg;

    localparam int DEF_LINE_MAX     = 256;
    localparam int DEF_MAX_COMMANDS = 32;
    localparam int DEF_QUEUE_DEPTH  = 4;

    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_EOL  = 2'd2;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_CR  = 8'h0d;
    localparam logic [7:0] CHAR_LF  = 8'h0a;
    localparam logic [7:0] CHAR_UA  = 8'h41;
    localparam logic [7:0] CHAR_UZ  = 8'h5a;
    localparam logic [7:0] CHAR_LA  = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX = 8'h66;
    localparam logic [7:0] CHAR_D0  = 8'h30;
    localparam logic [7:0] CHAR_D9  = 8'h39;
    localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [4:0] command_index;
        logic [6:0] byte_index;
        logic [5:0] command_count;
        logic       overflow;
    } result_t;

    // results caused by one input byte; r0 goes out first
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

endpackage

`default_nettype wire

>>> hdl/hex_command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// hex_command_line_tokenizer
// splits received bytes into lines of commands with hex data bytes
// ----------------------------------------------------------------------------
// One received byte is taken per clock while full is low. Each byte yields
// zero, one or two results (command start, data byte, end of line); the last
// result of a byte carries last. The front updates the parse state in the
// cycle a byte is taken, so input runs at one byte per cycle while full is
// low. Results leave through a queue of QUEUE_DEPTH entries and a registered
// output stage at one result per cycle while pop is high, so a byte with two
// results holds the output stage until both are popped; full rises only once
// the queue is filled by such bytes or by a stalled pop.
`default_nettype none

module hex_command_line_tokenizer #(
    parameter int LINE_MAX     = hctok_pkg::DEF_LINE_MAX,
    parameter int MAX_COMMANDS = hctok_pkg::DEF_MAX_COMMANDS,
    parameter int QUEUE_DEPTH  = hctok_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        pop,
    output logic             empty,
    output logic [1:0]       kind,
    output logic [7:0]       value,
    output logic [4:0]       command_index,
    output logic [6:0]       byte_index,
    output logic [5:0]       command_count,
    output logic             overflow,
    output logic             last
);
    import hctok_pkg::*;

    entry_t f_entry;
    logic   f_valid;
    entry_t q_entry;
    logic   q_not_empty;
    logic   q_pop;
    logic   accept;

    assign accept = push && !full;

    hctok_front #(
        .LINE_MAX     (LINE_MAX),
        .MAX_COMMANDS (MAX_COMMANDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .entry       (f_entry),
        .entry_valid (f_valid)
    );

    hctok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (f_valid),
        .wr_entry  (f_entry),
        .full      (full),
        .rd_en     (q_pop),
        .rd_entry  (q_entry),
        .not_empty (q_not_empty)
    );

    hctok_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_entry       (q_entry),
        .q_not_empty   (q_not_empty),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .kind          (kind),
        .value         (value),
        .command_index (command_index),
        .byte_index    (byte_index),
        .command_count (command_count),
        .overflow      (overflow),
        .last          (last)
    );

endmodule

`default_nettype wire

>>> hdl/hctok_front.sv
// ----------------------------------------------------------------------------
// hctok_front
// accepts bytes, tracks line and parse state, builds the results of each byte
// ----------------------------------------------------------------------------
`default_nettype none

module hctok_front #(
    parameter int LINE_MAX     = hctok_pkg::DEF_LINE_MAX,
    parameter int MAX_COMMANDS = hctok_pkg::DEF_MAX_COMMANDS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        rx_byte,
    output hctok_pkg::entry_t      entry,
    output logic                   entry_valid
);
    import hctok_pkg::*;

    localparam int LEN_W = $clog2(LINE_MAX + 1);
    localparam int CS_W  = $clog2(MAX_COMMANDS + 1);

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_CMD  = 2'd1;
    localparam logic [1:0] PH_NIB2 = 2'd2;
    localparam logic [1:0] PH_SKIP = 2'd3;

    logic [1:0]      phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic            halted_reg, halted_next;
    logic [3:0]      hn_reg, hn_next;
    logic [CS_W-1:0] cs_reg, cs_next;
    logic [6:0]      bic_reg, bic_next;
    logic            drop_reg, drop_next;

    logic            is_eol, is_letter, is_digit, is_alpha, is_hex;
    logic            do_end, do_parse, flush_ok, have_flush, main_valid;
    logic [3:0]      nib;
    result_t         flush_res, main_res;

    always_comb
    begin
        is_eol    = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
        is_letter = (rx_byte >= CHAR_UA) && (rx_byte <= CHAR_UZ);
        is_digit  = (rx_byte >= CHAR_D0) && (rx_byte <= CHAR_D9);
        is_alpha  = (rx_byte >= CHAR_LA) && (rx_byte <= CHAR_LF_HEX);
        is_hex    = is_digit || is_alpha;
        nib       = is_digit ? rx_byte[3:0] : 4'(rx_byte[3:0] + HEX_ALPHA_OFS);

        flush_ok  = (phase_reg == PH_NIB2) && (cs_reg != '0);

        flush_res.kind          = KIND_DATA;
        flush_res.value         = {hn_reg, 4'b0000};
        flush_res.command_index = 5'(cs_reg - 1'b1);
        flush_res.byte_index    = bic_reg;
        flush_res.command_count = 6'd0;
        flush_res.overflow      = drop_reg;

        main_res.kind          = KIND_DATA;
        main_res.value         = {hn_reg, nib};
        main_res.command_index = 5'(cs_reg - 1'b1);
        main_res.byte_index    = bic_reg;
        main_res.command_count = 6'd0;
        main_res.overflow      = drop_reg;

        phase_next  = phase_reg;
        len_next    = len_reg;
        halted_next = halted_reg;
        hn_next     = hn_reg;
        cs_next     = cs_reg;
        bic_next    = bic_reg;
        drop_next   = drop_reg;
        have_flush  = 1'b0;
        main_valid  = 1'b0;

        do_end   = 1'b0;
        do_parse = 1'b0;
        if (is_eol)
        begin
            do_end = (len_reg != '0);
        end
        else if (len_reg >= LEN_W'(LINE_MAX))
        begin
            // byte arriving on a full line closes it and is dropped
            do_end = 1'b1;
        end
        else
        begin
            len_next = LEN_W'(len_reg + 1'b1);
            do_parse = !halted_reg;
        end

        if (do_end)
        begin
            have_flush             = flush_ok;
            main_valid             = 1'b1;
            main_res.kind          = KIND_EOL;
            main_res.value         = 8'd0;
            main_res.command_index = 5'd0;
            main_res.byte_index    = 7'd0;
            main_res.command_count = 6'(cs_reg);
            phase_next  = PH_WAIT;
            len_next    = '0;
            halted_next = 1'b0;
            hn_next     = 4'd0;
            cs_next     = '0;
            bic_next    = 7'd0;
            drop_next   = 1'b0;
        end
        else if (do_parse)
        begin
            if (rx_byte == CHAR_NUL)
            begin
                have_flush = flush_ok;
                if (flush_ok)
                begin
                    bic_next = 7'(bic_reg + 1'b1);
                end
                halted_next = 1'b1;
                phase_next  = PH_WAIT;
            end
            else if (is_letter)
            begin
                have_flush = flush_ok;
                if (cs_reg < CS_W'(MAX_COMMANDS))
                begin
                    main_valid             = 1'b1;
                    main_res.kind          = KIND_CMD;
                    main_res.value         = rx_byte;
                    main_res.command_index = 5'(cs_reg);
                    main_res.byte_index    = 7'd0;
                    cs_next    = CS_W'(cs_reg + 1'b1);
                    bic_next   = 7'd0;
                    hn_next    = 4'd0;
                    phase_next = PH_CMD;
                end
                else
                begin
                    drop_next  = 1'b1;
                    phase_next = PH_SKIP;
                    if (flush_ok)
                    begin
                        bic_next = 7'(bic_reg + 1'b1);
                    end
                end
            end
            else if (is_hex)
            begin
                if (phase_reg == PH_CMD)
                begin
                    hn_next    = nib;
                    phase_next = PH_NIB2;
                end
                else if (phase_reg == PH_NIB2)
                begin
                    main_valid = 1'b1;
                    bic_next   = 7'(bic_reg + 1'b1);
                    phase_next = PH_CMD;
                end
            end
        end

        entry_valid = accept && (have_flush || main_valid);
        entry.two   = have_flush && main_valid;
        entry.r0    = have_flush ? flush_res : main_res;
        entry.r1    = main_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            len_reg    <= '0;
            halted_reg <= 1'b0;
            hn_reg     <= 4'd0;
            cs_reg     <= '0;
            bic_reg    <= 7'd0;
            drop_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            halted_reg <= halted_next;
            hn_reg     <= hn_next;
            cs_reg     <= cs_next;
            bic_reg    <= bic_next;
            drop_reg   <= drop_next;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(LINE_MAX))
        else $error("line length beyond limit");

    a_cs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cs_reg <= CS_W'(MAX_COMMANDS))
        else $error("command count beyond limit");

    a_nib_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NIB2) |-> (cs_reg != '0))
        else $error("pending nibble without a command");

    a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (phase_reg == PH_WAIT))
        else $error("parsing while line halted");

endmodule

`default_nettype wire

>>> hdl/hctok_queue.sv
// ----------------------------------------------------------------------------
// hctok_queue
// short queue of result entries between the front and the emitter
// ----------------------------------------------------------------------------
`default_nettype none

module hctok_queue #(
    parameter int DEPTH = hctok_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire hctok_pkg::entry_t  wr_entry,
    output logic                    full,
    input  wire logic               rd_en,
    output hctok_pkg::entry_t       rd_entry,
    output logic                    not_empty
);
    import hctok_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    always_comb
    begin
        full      = (cnt_reg == CNT_W'(DEPTH));
        not_empty = (cnt_reg != '0);
        do_wr     = wr_en && !full;
        do_rd     = rd_en && not_empty;
        rd_entry  = mem_reg[rp_reg];

        wp_next = wp_reg;
        if (do_wr)
        begin
            wp_next = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wp_reg + 1'b1);
        end
        rp_next = rp_reg;
        if (do_rd)
        begin
            rp_next = (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rp_reg + 1'b1);
        end
        cnt_next = cnt_reg;
        case ({do_wr, do_rd})
            2'b10:   cnt_next = CNT_W'(cnt_reg + 1'b1);
            2'b01:   cnt_next = CNT_W'(cnt_reg - 1'b1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_entry;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wp_reg == rp_reg))
        else $error("queue pointers apart while empty");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (cnt_reg == CNT_W'($past(cnt_reg) + 1'b1)))
        else $error("queue count missed a write");

endmodule

`default_nettype wire

>>> hdl/hctok_emit.sv
// ----------------------------------------------------------------------------
// hctok_emit
// holds one entry and hands its results out one transaction at a time
// ----------------------------------------------------------------------------
`default_nettype none

module hctok_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hctok_pkg::entry_t q_entry,
    input  wire logic          q_not_empty,
    output logic               q_pop,
    input  wire logic          pop,
    output logic               empty,
    output logic [1:0]         kind,
    output logic [7:0]         value,
    output logic [4:0]         command_index,
    output logic [6:0]         byte_index,
    output logic [5:0]         command_count,
    output logic               overflow,
    output logic               last
);
    import hctok_pkg::*;

    entry_t  ent_reg;
    logic    hold_reg, hold_next;
    logic    sel_reg, sel_next;
    result_t cur;
    logic    taken;

    always_comb
    begin
        cur   = sel_reg ? ent_reg.r1 : ent_reg.r0;
        last  = sel_reg || !ent_reg.two;
        empty = !hold_reg;
        taken = pop && hold_reg;

        // refill when nothing is held or the held entry is finishing
        q_pop = q_not_empty && (!hold_reg || (taken && last));

        hold_next = hold_reg;
        sel_next  = sel_reg;
        if (q_pop)
        begin
            hold_next = 1'b1;
            sel_next  = 1'b0;
        end
        else if (taken)
        begin
            if (last)
            begin
                hold_next = 1'b0;
                sel_next  = 1'b0;
            end
            else
            begin
                sel_next = 1'b1;
            end
        end

        kind          = cur.kind;
        value         = cur.value;
        command_index = cur.command_index;
        byte_index    = cur.byte_index;
        command_count = cur.command_count;
        overflow      = cur.overflow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
            sel_reg  <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ent_reg <= q_entry;
        end
    end

    a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (hold_reg && ent_reg.two))
        else $error("second result selected on a single entry");

    a_no_early_pull: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_reg && !(pop && last)) |-> !q_pop)
        else $error("entry pulled while one is still pending");

    a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
        (taken && !last) |=> (hold_reg && sel_reg))
        else $error("second result lost");

endmodule

`default_nettype wire
